>>> rtl/core/lmrs_pkg.sv
`timescale 1ns / 1ps

package lmrs_pkg;

   // Default geometry
   localparam int DEF_PANEL_WIDTH = 32;
   localparam int DEF_MAX_BUFFERS = 8;
   localparam int MAX_PLANES      = 16;
   localparam int BUF_BYTES       = 128;
   localparam int BUF_AW          = 7;

   // Request operation codes
   localparam logic OP_WRITE = 1'b0;
   localparam logic OP_TICK  = 1'b1;

   // Register port
   localparam int CSR_IW = 3;
   localparam int CSR_DW = 5;
   localparam logic [CSR_IW-1:0] CSR_PLANE_COUNT      = 3'd0;
   localparam logic [CSR_IW-1:0] CSR_BUFFER_COUNT     = 3'd1;
   localparam logic [CSR_IW-1:0] CSR_BRIGHTNESS_LEVEL = 3'd2;
   localparam logic [CSR_IW-1:0] CSR_CLOCK_BRIGHTNESS = 3'd3;
   localparam logic [CSR_IW-1:0] CSR_CLOCK_COLOR      = 3'd4;
   localparam logic [CSR_IW-1:0] CSR_ANIM_COLOR       = 3'd5;

   localparam logic [4:0] RST_PLANE_COUNT  = 5'd8;
   localparam logic [3:0] RST_BUFFER_COUNT = 4'd5;

   // Color modes
   localparam logic [1:0] MODE_RED   = 2'd0;
   localparam logic [1:0] MODE_GREEN = 2'd1;

   // Word coding masks
   localparam logic [7:0] TOP_MASK   = 8'b11000000;
   localparam logic [7:0] RED_FILL   = 8'b00110000;
   localparam logic [7:0] GREEN_FILL = 8'b11000000;
   localparam logic [7:0] FILL_BYTE  = 8'hFF;

   // On-time terms
   localparam logic [15:0] ON_BASE       = 16'd200;
   localparam logic [15:0] ON_BUF1_EXTRA = 16'd2300;
   localparam logic [15:0] ON_CLOCK_STEP = 16'd800;

   // Special buffers and row addressing
   localparam logic [2:0] BUF_BONUS       = 3'd1;
   localparam logic [2:0] BUF_CLOCK       = 3'd2;
   localparam logic [4:0] ROW_WIDE_PLANES = 5'd8;

   typedef struct packed {
      logic clear_step;
      logic mem_write;
      logic start;
      logic read;
      logic load;
      logic emit;
      logic advance;
   } cmd_type;

   typedef struct packed {
      logic clear_last;
      logic out_free;
      logic last_word;
      logic last_byte;
   } status_type;

endpackage

>>> rtl/core/lmrs_ram.sv
`timescale 1ns / 1ps

module lmrs_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 1024,
   localparam int AW = $clog2(DEPTH)
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> rtl/core/lmrs_ctrl.sv
`timescale 1ns / 1ps

module lmrs_ctrl
   import lmrs_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic       req_operation,
   input  status_type status,
   output cmd_type    cmd
);

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_READ,
      ST_LOAD,
      ST_SHIFT
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         ST_CLEAR: begin
            cmd.clear_step = 1'b1;
            if (status.clear_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               if (req_operation == OP_TICK) begin
                  cmd.start = 1'b1;
                  state_in  = ST_READ;
               end else begin
                  cmd.mem_write = 1'b1;
               end
            end
         end
         ST_READ: begin
            cmd.read = 1'b1;
            state_in = ST_LOAD;
         end
         ST_LOAD: begin
            // take the first byte, prefetch the second
            cmd.load = 1'b1;
            cmd.read = 1'b1;
            state_in = ST_SHIFT;
         end
         ST_SHIFT: begin
            if (status.out_free) begin
               cmd.emit = 1'b1;
               if (status.last_word) begin
                  if (status.last_byte) begin
                     cmd.advance = 1'b1;
                     state_in    = ST_IDLE;
                  end else begin
                     cmd.read = 1'b1;
                  end
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

>>> rtl/core/lmrs_dp.sv
`timescale 1ns / 1ps

module lmrs_dp
   import lmrs_pkg::*;
#(
   parameter int PANEL_WIDTH = DEF_PANEL_WIDTH,
   parameter int MAX_BUFFERS = DEF_MAX_BUFFERS
) (
   input  logic              clock,
   input  logic              reset,
   input  cmd_type           cmd,
   output status_type        status,
   input  logic [2:0]        req_buffer_select,
   input  logic [6:0]        req_byte_address,
   input  logic [7:0]        req_write_data,
   input  logic              csr_write_enable,
   input  logic [CSR_IW-1:0] csr_index,
   input  logic [CSR_DW-1:0] csr_write_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic [7:0]        rsp_data_lines,
   output logic [3:0]        rsp_row_address,
   output logic              rsp_latch_last,
   output logic [15:0]       rsp_on_time,
   output logic [2:0]        rsp_shown_buffer
);

   localparam int DEPTH = MAX_BUFFERS * BUF_BYTES;
   localparam int AW    = $clog2(DEPTH);
   localparam int BYTES = PANEL_WIDTH / 4;
   localparam int XW    = $clog2(BYTES);

   function automatic logic [7:0] code_word(input logic [7:0] p, input logic [1:0] mode);
      logic [7:0] top;
      top = p & TOP_MASK;
      case (mode)
         MODE_GREEN: code_word = (top >> 2) | GREEN_FILL;
         MODE_RED:   code_word = top | RED_FILL;
         default:    code_word = top | (top >> 2);
      endcase
   endfunction

   // Configuration
   logic [4:0] plane_count_ff;
   logic [3:0] buffer_count_ff;
   logic [3:0] brightness_ff;
   logic [3:0] clock_bright_ff;
   logic [1:0] clock_color_ff;
   logic [1:0] anim_color_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         plane_count_ff  <= RST_PLANE_COUNT;
         buffer_count_ff <= RST_BUFFER_COUNT;
         brightness_ff   <= '0;
         clock_bright_ff <= '0;
         clock_color_ff  <= MODE_RED;
         anim_color_ff   <= MODE_RED;
      end else if (csr_write_enable) begin
         case (csr_index)
            CSR_PLANE_COUNT:      plane_count_ff  <= csr_write_data;
            CSR_BUFFER_COUNT:     buffer_count_ff <= csr_write_data[3:0];
            CSR_BRIGHTNESS_LEVEL: brightness_ff   <= csr_write_data[3:0];
            CSR_CLOCK_BRIGHTNESS: clock_bright_ff <= csr_write_data[3:0];
            CSR_CLOCK_COLOR:      clock_color_ff  <= csr_write_data[1:0];
            CSR_ANIM_COLOR:       anim_color_ff   <= csr_write_data[1:0];
            default: ;
         endcase
      end
   end

   // Frame store and clearing pass
   logic [AW-1:0] clr_ff;
   logic [9:0]    wr_full;
   logic          sel_ok;
   logic          ram_wr_en;
   logic [AW-1:0] ram_wr_addr;
   logic [7:0]    ram_wr_data;
   logic [AW-1:0] ram_rd_addr;
   logic [7:0]    ram_rd_data;

   logic [2:0]    buf_ff;
   logic [6:0]    ptr_ff;
   logic [9:0]    rd_full;

   assign wr_full     = {req_buffer_select, req_byte_address};
   assign sel_ok      = {1'b0, req_buffer_select} < 4'(MAX_BUFFERS);
   assign ram_wr_en   = cmd.clear_step || (cmd.mem_write && sel_ok);
   assign ram_wr_addr = cmd.clear_step ? clr_ff : wr_full[AW-1:0];
   assign ram_wr_data = cmd.clear_step ? FILL_BYTE : req_write_data;
   assign rd_full     = {buf_ff, ptr_ff};
   assign ram_rd_addr = rd_full[AW-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff <= '0;
      end else if (cmd.clear_step) begin
         clr_ff <= clr_ff + 1'b1;
      end
   end

   lmrs_ram #(
      .WIDTH(8),
      .DEPTH(DEPTH)
   ) u_frame_store (
      .clock  (clock),
      .wr_en  (ram_wr_en),
      .wr_addr(ram_wr_addr),
      .wr_data(ram_wr_data),
      .rd_en  (cmd.read),
      .rd_addr(ram_rd_addr),
      .rd_data(ram_rd_data)
   );

   // Scan position
   logic [3:0] cur_plane_ff;
   logic [2:0] cur_buf_ff;
   logic [2:0] buf_sel;
   logic [4:0] planes_sat;
   logic [3:0] bufs_sat;
   logic [3:0] next_plane;
   logic [3:0] next_buf;

   assign buf_sel    = ({1'b0, cur_buf_ff} >= 4'(MAX_BUFFERS)) ? 3'd0 : cur_buf_ff;
   assign planes_sat = (plane_count_ff > 5'(MAX_PLANES)) ? 5'(MAX_PLANES) : plane_count_ff;
   assign bufs_sat   = (buffer_count_ff > 4'(MAX_BUFFERS)) ? 4'(MAX_BUFFERS)
                                                           : buffer_count_ff;
   assign next_plane = cur_plane_ff + 4'd1;
   assign next_buf   = {1'b0, buf_ff} + 4'd1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_plane_ff <= '0;
         cur_buf_ff   <= '0;
      end else if (cmd.advance) begin
         if (({1'b0, next_plane} >= planes_sat) || (next_plane == 4'd0)) begin
            cur_plane_ff <= '0;
            cur_buf_ff   <= (next_buf >= bufs_sat) ? 3'd0 : next_buf[2:0];
         end else begin
            cur_plane_ff <= next_plane;
         end
      end
   end

   // Per-run parameters, latched at tick start
   logic [1:0]  mode_ff;
   logic [3:0]  row_ff;
   logic [15:0] on_time_ff;
   logic [15:0] on_calc;
   logic [7:0]  base_full;

   always_comb begin
      on_calc = ON_BASE + ON_BASE * 16'(brightness_ff);
      if (buf_sel == BUF_BONUS) begin
         on_calc = on_calc + ON_BUF1_EXTRA;
      end
      if (buf_sel == BUF_CLOCK) begin
         on_calc = on_calc + ON_CLOCK_STEP * 16'(clock_bright_ff);
      end
   end

   assign base_full = 8'(cur_plane_ff) * 8'(BYTES);

   // Shift engine
   logic [7:0]    byte_ff;
   logic [1:0]    word_ff;
   logic [XW-1:0] xb_ff;

   assign status.clear_last = (clr_ff == AW'(DEPTH - 1));
   assign status.out_free   = !rsp_valid || rsp_ready;
   assign status.last_word  = (word_ff == 2'd3);
   assign status.last_byte  = (xb_ff == XW'(BYTES - 1));

   always_ff @(posedge clock) begin
      if (cmd.start) begin
         buf_ff     <= buf_sel;
         mode_ff    <= (buf_sel == BUF_CLOCK) ? clock_color_ff : anim_color_ff;
         row_ff     <= (plane_count_ff > ROW_WIDE_PLANES) ? cur_plane_ff
                                                          : {1'b0, cur_plane_ff[2:0]};
         on_time_ff <= on_calc;
         ptr_ff     <= base_full[6:0];
      end else if (cmd.read) begin
         ptr_ff <= ptr_ff + 7'd1;
      end

      if (cmd.load) begin
         byte_ff <= ram_rd_data;
         word_ff <= '0;
         xb_ff   <= '0;
      end else if (cmd.emit) begin
         if (status.last_word && !status.last_byte) begin
            // next byte was prefetched four words ago
            byte_ff <= ram_rd_data;
            word_ff <= '0;
            xb_ff   <= xb_ff + 1'b1;
         end else begin
            byte_ff <= byte_ff << 2;
            word_ff <= word_ff + 2'd1;
         end
      end
   end

   // Output register
   logic        rsp_valid_ff;
   logic [7:0]  data_lines_ff;
   logic [3:0]  row_address_ff;
   logic        latch_last_ff;
   logic [15:0] on_time_out_ff;
   logic [2:0]  shown_buffer_ff;
   logic        last_in;

   assign last_in = status.last_word && status.last_byte;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         data_lines_ff   <= code_word(byte_ff, mode_ff);
         row_address_ff  <= row_ff;
         latch_last_ff   <= last_in;
         on_time_out_ff  <= last_in ? on_time_ff : 16'd0;
         shown_buffer_ff <= buf_ff;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_data_lines   = data_lines_ff;
   assign rsp_row_address  = row_address_ff;
   assign rsp_latch_last   = latch_last_ff;
   assign rsp_on_time      = on_time_out_ff;
   assign rsp_shown_buffer = shown_buffer_ff;

endmodule

>>> rtl/core/led_matrix_row_scan_refresh_top.sv
`timescale 1ns / 1ps
// Channel  Direction  Handshake                Payload
// req      in         req_valid / req_ready    operation, buffer_select, byte_address,
//                                              write_data
// rsp      out        rsp_valid / rsp_ready    data_lines, row_address, latch_last,
//                                              on_time, shown_buffer
// csr      in         csr_write_enable         csr_index, csr_write_data
//
// A write word is taken in the idle state. A tick word does one RAM read per byte, plus
// one prefetch past the last byte, and sends four data words per byte.
// After reset a clearing pass fills the frame store with all ones, one byte a
// cycle, all MAX_BUFFERS*128 bytes (1024 by default); req_ready stays low meanwhile.
// A stalled rsp holds the shift engine; register writes are taken at any time.

module led_matrix_row_scan_refresh_top
   import lmrs_pkg::*;
#(
   parameter int PANEL_WIDTH = DEF_PANEL_WIDTH,
   parameter int MAX_BUFFERS = DEF_MAX_BUFFERS
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  logic              req_operation,
   input  logic [2:0]        req_buffer_select,
   input  logic [6:0]        req_byte_address,
   input  logic [7:0]        req_write_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic [7:0]        rsp_data_lines,
   output logic [3:0]        rsp_row_address,
   output logic              rsp_latch_last,
   output logic [15:0]       rsp_on_time,
   output logic [2:0]        rsp_shown_buffer,
   input  logic              csr_write_enable,
   input  logic [CSR_IW-1:0] csr_index,
   input  logic [CSR_DW-1:0] csr_write_data
);

   cmd_type    ctrl_cmd;
   status_type dp_status;

   // Sequence clearing, byte writes and the per-tick shift run
   lmrs_ctrl u_ctrl (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_operation(req_operation),
      .status       (dp_status),
      .cmd          (ctrl_cmd)
   );

   // Hold frame store, scan counters, registers and the output word
   lmrs_dp #(
      .PANEL_WIDTH(PANEL_WIDTH),
      .MAX_BUFFERS(MAX_BUFFERS)
   ) u_dp (
      .clock            (clock),
      .reset            (reset),
      .cmd              (ctrl_cmd),
      .status           (dp_status),
      .req_buffer_select(req_buffer_select),
      .req_byte_address (req_byte_address),
      .req_write_data   (req_write_data),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_data_lines   (rsp_data_lines),
      .rsp_row_address  (rsp_row_address),
      .rsp_latch_last   (rsp_latch_last),
      .rsp_on_time      (rsp_on_time),
      .rsp_shown_buffer (rsp_shown_buffer)
   );

   // Never overwrite an output word that has not been taken
   a_emit_free: assert property (@(posedge clock) disable iff (reset)
      ctrl_cmd.emit |-> (!rsp_valid || rsp_ready))
      else $error("word emitted over a pending output word");

   // On-time is nonzero exactly on the latch word
   a_on_time_latch: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_latch_last == (rsp_on_time != 16'd0)))
      else $error("on_time does not match latch_last");

   // A tick blocks further requests while the run is shifted out
   a_tick_blocks: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready && (req_operation == OP_TICK)) |=> !req_ready)
      else $error("request taken during a refresh run");

   // Store writes, run start, clearing and emission never overlap
   a_cmd_exclusive: assert property (@(posedge clock) disable iff (reset)
      $onehot0({ctrl_cmd.mem_write, ctrl_cmd.start, ctrl_cmd.emit, ctrl_cmd.clear_step}))
      else $error("conflicting datapath commands");

endmodule
